/* rtl/lcd_mode_line_timer_top_macros.svh */
// Assertion macros used by the LCD mode and line timer RTL.
`ifndef LCD_MODE_LINE_TIMER_TOP_MACROS_SVH
`define LCD_MODE_LINE_TIMER_TOP_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define LMT_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lcd mode line timer: same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define LMT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lcd mode line timer: next-cycle check failed");

`endif

/* rtl/lcdmlt_pkg.sv */
// Types and constants of the LCD mode and line timer.
package lcdmlt_pkg;

   localparam int ACC_W  = 10;
   localparam int LINE_W = 8;
   localparam int MODE_W = 2;
   localparam int ELAP_W = 6;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // LCD modes
   localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
   localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SCAN   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_XFER   = 2'd3;

   // Cycle budgets of each mode
   localparam logic [ACC_W-1:0] BUDGET_HBLANK = 10'd204;
   localparam logic [ACC_W-1:0] BUDGET_VBLANK = 10'd456;
   localparam logic [ACC_W-1:0] BUDGET_SCAN   = 10'd80;
   localparam logic [ACC_W-1:0] BUDGET_XFER   = 10'd172;

   // Largest accumulator value: vblank budget minus one plus the largest tick
   localparam logic [ACC_W-1:0] ACC_MAX = 10'd518;

   localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = 8'h90;
   localparam logic [LINE_W-1:0] LINES_PER_FRAME   = 8'd154;
   localparam logic [LINE_W-1:0] LAST_LINE         = 8'd153;

   // Register indexes (byte address divided by four)
   localparam logic [2:0] REG_LCD_ENABLE    = 3'd0;
   localparam logic [2:0] REG_LINE_COMPARE  = 3'd1;
   localparam logic [2:0] REG_HBLANK_IRQ_EN = 3'd2;
   localparam logic [2:0] REG_VBLANK_IRQ_EN = 3'd3;
   localparam logic [2:0] REG_OAM_IRQ_EN    = 3'd4;
   localparam logic [2:0] REG_MATCH_IRQ_EN  = 3'd5;

   // One result item
   typedef struct packed {
      logic              vblank_irq;
      logic              stat_irq;
      logic              line_start;
      logic [LINE_W-1:0] line_number;
      logic [MODE_W-1:0] mode_now;
      logic              line_match;
   } result_type;

endpackage

/* rtl/lcd_mode_line_timer_top.sv */
// A tick's result is registered into the output register, or into the skid entry
// while a result is stalled. Throughput: one tick per cycle while the skid entry is
// empty; the add, budget compare and subtract on the 10-bit cycle accumulator are
// combinational between the state registers. A two-entry output buffer takes one
// more tick while a result is stalled. Reset (synchronous, active high): registers
// 0, accumulator 0, line 0, mode object scan, match flag 0, no result pending.
`include "lcd_mode_line_timer_top_macros.svh"

module lcd_mode_line_timer_top (
   input  logic                              clock,
   input  logic                              reset,
   // tick channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lcdmlt_pkg::ELAP_W-1:0]     req_elapsed_cycles,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_vblank_irq,
   output logic                              rsp_stat_irq,
   output logic                              rsp_line_start,
   output logic [lcdmlt_pkg::LINE_W-1:0]     rsp_line_number,
   output logic [lcdmlt_pkg::MODE_W-1:0]     rsp_mode_now,
   output logic                              rsp_line_match,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lcdmlt_pkg::ADDR_W-1:0]     paddr,
   input  logic [lcdmlt_pkg::DATA_W-1:0]     pwdata,
   output logic [lcdmlt_pkg::DATA_W-1:0]     prdata,
   output logic                              pready
);
   import lcdmlt_pkg::*;

   // configuration registers
   logic              lcd_enable_ff;
   logic [LINE_W-1:0] line_compare_ff;
   logic              hblank_irq_en_ff;
   logic              vblank_irq_en_ff;
   logic              oam_irq_en_ff;
   logic              match_irq_en_ff;

   // timing state
   logic [ACC_W-1:0]  accum_ff,  accum_in;
   logic [MODE_W-1:0] mode_ff,   mode_in;
   logic [LINE_W-1:0] line_ff,   line_in;
   logic              match_ff,  match_in;

   // output buffer
   result_type        out_ff, out_in;
   result_type        skid_ff, skid_in;
   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   result_type        result;

   logic              req_fire;
   logic              rsp_fire;
   logic              csr_write;
   logic [2:0]        reg_index;
   logic [ACC_W-1:0]  sum;
   logic [LINE_W-1:0] line_inc;
   logic              vbl;
   logic              st;
   logic              start;

   assign pready    = 1'b1;
   assign reg_index = paddr[ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lcd_enable_ff    <= 1'b0;
         line_compare_ff  <= '0;
         hblank_irq_en_ff <= 1'b0;
         vblank_irq_en_ff <= 1'b0;
         oam_irq_en_ff    <= 1'b0;
         match_irq_en_ff  <= 1'b0;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_LCD_ENABLE:    lcd_enable_ff    <= pwdata[0];
            REG_LINE_COMPARE:  line_compare_ff  <= pwdata[LINE_W-1:0];
            REG_HBLANK_IRQ_EN: hblank_irq_en_ff <= pwdata[0];
            REG_VBLANK_IRQ_EN: vblank_irq_en_ff <= pwdata[0];
            REG_OAM_IRQ_EN:    oam_irq_en_ff    <= pwdata[0];
            REG_MATCH_IRQ_EN:  match_irq_en_ff  <= pwdata[0];
            default: ;
         endcase
      end
   end

   // read back configuration registers
   always_comb begin
      prdata = '0;
      unique case (reg_index)
         REG_LCD_ENABLE:    prdata[0]          = lcd_enable_ff;
         REG_LINE_COMPARE:  prdata[LINE_W-1:0] = line_compare_ff;
         REG_HBLANK_IRQ_EN: prdata[0]          = hblank_irq_en_ff;
         REG_VBLANK_IRQ_EN: prdata[0]          = vblank_irq_en_ff;
         REG_OAM_IRQ_EN:    prdata[0]          = oam_irq_en_ff;
         REG_MATCH_IRQ_EN:  prdata[0]          = match_irq_en_ff;
         default:           prdata             = '0;
      endcase
   end

   // handshakes
   assign req_ready = !skid_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_fire  = out_valid_ff && rsp_ready;

   assign sum      = accum_ff + {{(ACC_W-ELAP_W){1'b0}}, req_elapsed_cycles};
   assign line_inc = line_ff + 8'd1;

   // advance accumulator, mode, line and match flag for one tick while the LCD is enabled
   always_comb begin
      accum_in = accum_ff;
      mode_in  = mode_ff;
      line_in  = line_ff;
      match_in = match_ff;
      vbl      = 1'b0;
      st       = 1'b0;
      start    = 1'b0;
      if (lcd_enable_ff) begin
         accum_in = sum;
         unique case (mode_ff)
            MODE_HBLANK: begin
               if (sum >= BUDGET_HBLANK) begin
                  accum_in = sum - BUDGET_HBLANK;
                  line_in  = line_inc;
                  if (line_inc == FIRST_VBLANK_LINE) begin
                     mode_in = MODE_VBLANK;
                     vbl     = 1'b1;
                     st      = vblank_irq_en_ff;
                  end else begin
                     mode_in = MODE_SCAN;
                     st      = oam_irq_en_ff;
                  end
                  match_in = (line_inc == line_compare_ff);
                  st       = st | (match_in & match_irq_en_ff);
               end
            end
            MODE_VBLANK: begin
               if (sum >= BUDGET_VBLANK) begin
                  accum_in = sum - BUDGET_VBLANK;
                  if (line_inc >= LINES_PER_FRAME) begin
                     line_in = '0;
                     mode_in = MODE_SCAN;
                     st      = oam_irq_en_ff;
                  end else begin
                     line_in = line_inc;
                  end
                  match_in = (line_in == line_compare_ff);
                  st       = st | (match_in & match_irq_en_ff);
               end
            end
            MODE_SCAN: begin
               if (sum >= BUDGET_SCAN) begin
                  accum_in = sum - BUDGET_SCAN;
                  mode_in  = MODE_XFER;
                  start    = 1'b1;
               end
            end
            MODE_XFER: begin
               if (sum >= BUDGET_XFER) begin
                  accum_in = sum - BUDGET_XFER;
                  mode_in  = MODE_HBLANK;
                  st       = hblank_irq_en_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // assemble the result item of this tick
   always_comb begin
      result.vblank_irq  = vbl;
      result.stat_irq    = st;
      result.line_start  = start;
      result.line_number = line_in;
      result.mode_now    = mode_in;
      result.line_match  = match_in;
   end

   // hold timing state, advance on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
         mode_ff  <= MODE_SCAN;
         line_ff  <= '0;
         match_ff <= 1'b0;
      end else if (req_fire) begin
         accum_ff <= accum_in;
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         match_ff <= match_in;
      end
   end

   // steer results into the output register or the skid entry
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_fire) begin
         if (!out_valid_ff || rsp_fire) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_fire) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_vblank_irq  = out_ff.vblank_irq;
   assign rsp_stat_irq    = out_ff.stat_irq;
   assign rsp_line_start  = out_ff.line_start;
   assign rsp_line_number = out_ff.line_number;
   assign rsp_mode_now    = out_ff.mode_now;
   assign rsp_line_match  = out_ff.line_match;

   // checks
   `LMT_ASSERT_SAME(a_skid_behind_out, skid_valid_ff, out_valid_ff)
   `LMT_ASSERT_SAME(a_accum_headroom, 1'b1, accum_ff <= ACC_MAX)
   `LMT_ASSERT_SAME(a_line_bound, 1'b1, line_ff <= LAST_LINE)
   `LMT_ASSERT_NEXT(a_disabled_holds, req_fire && !lcd_enable_ff,
      $stable(accum_ff) && $stable(mode_ff) && $stable(line_ff))
   `LMT_ASSERT_SAME(a_vblank_pulse_mode, out_valid_ff && out_ff.vblank_irq,
      out_ff.mode_now == MODE_VBLANK && out_ff.line_number == FIRST_VBLANK_LINE)

endmodule
